// ===== rtl/core/smsk_pkg.sv =====
// Package for the shared-pool multi-stack: transaction structs, operation codes
// and the command passed from the front part to the back part.
// No dependencies.
package smsk_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         stack_id;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] top_value;
        logic               stack_empty;
        logic               pool_full;
    } rsp_t;

    // Classified operation; K_QUERY reports like a peek but never succeeds.
    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_PEEK,
        K_QUERY,
        K_NOSTACK
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  stack_id;
        logic [31:0] value;
    } cmd_t;

endpackage

// ===== rtl/core/smsk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/smsk_front.sv =====
// Front part: accepts request transactions, classifies them and holds them
// in a two-entry queue for the back part. Depends on smsk_pkg.
module smsk_front import smsk_pkg::*; #(
    parameter int STACKS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd
);

    cmd_t       q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    cmd_t       cls;
    logic       push;
    logic       in_range;

    assign in_range = {30'd0, req.stack_id} < 32'(STACKS);

    always_comb
    begin
        cls.stack_id = req.stack_id;
        cls.value    = $unsigned(req.push_value);
        if (!in_range)
        begin
            cls.kind = K_NOSTACK;
        end
        else
        begin
            unique case (req.operation)
                OP_PUSH: cls.kind = K_PUSH;
                OP_POP:  cls.kind = K_POP;
                OP_PEEK: cls.kind = K_PEEK;
                default: cls.kind = K_QUERY;
            endcase
        end
    end

    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (cmd_take)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !cmd_take)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && cmd_take)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/smsk_back.sv =====
// Back part: carries out one command at a time against the entry pool
// (data, link and stack-head RAMs) and holds the response register.
// Depends on smsk_pkg and smsk_ram.
module smsk_back import smsk_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int STACKS     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_take,
    input  logic signed [31:0] empty_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = IW + 1;
    localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam int HW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HEAD   = 4'b0010,
        S_UNLINK = 4'b0100,
        S_DATA   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [SW-1:0]       sel_reg, sel_next;
    logic                hv_reg, hv_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       link_addr_reg, link_addr_next;
    logic                link_fresh_reg, link_fresh_next;
    logic                ok_reg, ok_next;
    logic [LW-1:0]       free_head_reg, free_head_next;
    logic [HW-1:0]       fresh_reg, fresh_next;
    logic [STACKS-1:0]   head_vld_reg, head_vld_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                head_we;
    logic [SW-1:0]       head_waddr, head_raddr;
    logic [LW-1:0]       head_wdata, head_rdata;
    logic                link_we;
    logic [IW-1:0]       link_waddr, link_raddr;
    logic [LW-1:0]       link_wdata, link_rdata;
    logic                data_we;
    logic [IW-1:0]       data_waddr, data_raddr;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

    logic [LW-1:0]       link_val;
    logic [LW-1:0]       head_val;
    logic                free_null, head_null, link_null;
    logic [DATA_WIDTH-1:0] push_word;
    logic [31:0]         push_top;
    logic [31:0]         data_top;
    logic [SW-1:0]       in_sel;

    // Entries at or above the high-water count have never had their link
    // written, so their link is still the reset chain to the next entry.
    assign link_val  = link_fresh_reg ? LW'({1'b0, link_addr_reg} + LW'(1)) : link_rdata;
    assign head_val  = hv_reg ? head_rdata : NULL_LINK;
    assign free_null = (free_head_reg >= NULL_LINK);
    assign head_null = (head_val >= NULL_LINK);
    assign link_null = (link_val >= NULL_LINK);
    assign push_word = DATA_WIDTH'(cmd_reg.value);
    assign push_top  = 32'(push_word);
    assign data_top  = 32'(data_rdata);
    assign in_sel    = SW'(cmd.stack_id);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        sel_next        = sel_reg;
        hv_next         = hv_reg;
        cur_next        = cur_reg;
        link_addr_next  = link_addr_reg;
        link_fresh_next = link_fresh_reg;
        ok_next         = ok_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        head_vld_next   = head_vld_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        cmd_take        = 1'b0;
        head_we         = 1'b0;
        head_waddr      = sel_reg;
        head_wdata      = link_val;
        head_raddr      = in_sel;
        link_we         = 1'b0;
        link_waddr      = cur_reg;
        link_wdata      = free_head_reg;
        link_raddr      = free_head_reg[IW-1:0];
        data_we         = 1'b0;
        data_waddr      = free_head_reg[IW-1:0];
        data_wdata      = push_word;
        data_raddr      = head_val[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // The response register is free by the time any command ends.
                if (cmd_valid && (!rsp_valid_reg || !rsp_stall))
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    sel_next = in_sel;
                    if (cmd.kind == K_NOSTACK)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.ok          = 1'b0;
                        rsp_next.top_value   = empty_value;
                        rsp_next.stack_empty = 1'b1;
                        rsp_next.pool_full   = free_null;
                    end
                    else
                    begin
                        hv_next         = head_vld_reg[in_sel];
                        link_addr_next  = free_head_reg[IW-1:0];
                        link_fresh_next = (free_head_reg >= LW'(fresh_reg));
                        state_next      = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                case (cmd_reg.kind)
                    K_PUSH:
                    begin
                        if (!free_null)
                        begin
                            data_we    = 1'b1;
                            link_we    = 1'b1;
                            link_waddr = free_head_reg[IW-1:0];
                            link_wdata = head_val;
                            head_we    = 1'b1;
                            head_wdata = free_head_reg;
                            head_vld_next[sel_reg] = 1'b1;
                            free_head_next = link_val;
                            if (free_head_reg == LW'(fresh_reg))
                            begin
                                fresh_next = fresh_reg + HW'(1);
                            end
                            rsp_valid_next       = 1'b1;
                            rsp_next.ok          = 1'b1;
                            rsp_next.top_value   = $signed(push_top);
                            rsp_next.stack_empty = 1'b0;
                            rsp_next.pool_full   = link_null;
                            state_next           = S_IDLE;
                        end
                        else if (head_null)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.ok          = 1'b0;
                            rsp_next.top_value   = empty_value;
                            rsp_next.stack_empty = 1'b1;
                            rsp_next.pool_full   = 1'b1;
                            state_next           = S_IDLE;
                        end
                        else
                        begin
                            ok_next    = 1'b0;
                            state_next = S_DATA;
                        end
                    end
                    K_POP:
                    begin
                        if (head_null)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.ok          = 1'b0;
                            rsp_next.top_value   = empty_value;
                            rsp_next.stack_empty = 1'b1;
                            rsp_next.pool_full   = free_null;
                            state_next           = S_IDLE;
                        end
                        else
                        begin
                            link_raddr      = head_val[IW-1:0];
                            link_addr_next  = head_val[IW-1:0];
                            link_fresh_next = (head_val >= LW'(fresh_reg));
                            cur_next        = head_val[IW-1:0];
                            state_next      = S_UNLINK;
                        end
                    end
                    default:
                    begin
                        if (head_null)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.ok          = 1'b0;
                            rsp_next.top_value   = empty_value;
                            rsp_next.stack_empty = 1'b1;
                            rsp_next.pool_full   = free_null;
                            state_next           = S_IDLE;
                        end
                        else
                        begin
                            ok_next    = (cmd_reg.kind == K_PEEK);
                            state_next = S_DATA;
                        end
                    end
                endcase
            end
            S_UNLINK:
            begin
                // The popped entry goes back to the front of the free list.
                head_we        = 1'b1;
                link_we        = 1'b1;
                free_head_next = {1'b0, cur_reg};
                data_raddr     = link_val[IW-1:0];
                if (link_null)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.ok          = 1'b1;
                    rsp_next.top_value   = empty_value;
                    rsp_next.stack_empty = 1'b1;
                    rsp_next.pool_full   = 1'b0;
                    state_next           = S_IDLE;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.ok          = ok_reg;
                rsp_next.top_value   = $signed(data_top);
                rsp_next.stack_empty = 1'b0;
                rsp_next.pool_full   = free_null;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            head_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            head_vld_reg  <= head_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        sel_reg        <= sel_next;
        hv_reg         <= hv_next;
        cur_reg        <= cur_next;
        link_addr_reg  <= link_addr_next;
        link_fresh_reg <= link_fresh_next;
        ok_reg         <= ok_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    smsk_ram #(.WIDTH(LW), .DEPTH(STACKS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    smsk_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    smsk_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

endmodule

// ===== rtl/core/shared_pool_multi_stack.sv =====
// The back part carries out one request transaction at a time and takes no new one until
// it is idle again; each steps through the registered RAM reads it needs (head, then link
// for a pop, then data), and one whose stack number is beyond STACKS is answered at once.
// A two-entry queue lets requests be accepted while the back part or output stalls.
// Reset clears the queue, stack-head valid bits, free-list head and high-water
// count at once; no clearing pass is needed and empty_value resets to zero.
module shared_pool_multi_stack import smsk_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int STACKS     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data
);

    logic signed [31:0] empty_value_reg;
    logic               cmd_valid;
    logic               cmd_take;
    cmd_t               cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_value_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            empty_value_reg <= cfg_data;
        end
    end

    smsk_front #(.STACKS(STACKS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    smsk_back #(
        .ENTRIES    (ENTRIES),
        .STACKS     (STACKS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .empty_value (empty_value_reg),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

// ===== rtl/core/smsk_checker.sv =====
// Port-level checker for the shared-pool multi-stack, bound to the top level.
// Depends on smsk_pkg and shared_pool_multi_stack.
module smsk_checker import smsk_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input req_t               req,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input rsp_t               rsp,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic signed [31:0] cfg_data
);

    logic signed [31:0] empty_shadow_reg;
    logic [3:0]         pending_reg;
    logic               req_fire;
    logic               rsp_fire;

    assign req_fire = req_valid && !req_stall;
    assign rsp_fire = rsp_valid && !rsp_stall;

    // Mirror of the configured empty value and of transactions still owed a response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_shadow_reg <= '0;
            pending_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                empty_shadow_reg <= cfg_data;
            end
            if (req_fire && !rsp_fire)
            begin
                pending_reg <= pending_reg + 4'd1;
            end
            else if (!req_fire && rsp_fire)
            begin
                pending_reg <= pending_reg - 4'd1;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("response without an outstanding request");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stack_empty |-> rsp.top_value == empty_shadow_reg)
        else $error("empty stack reported a top other than the empty value");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ok && rsp.stack_empty |-> !rsp.pool_full)
        else $error("pool full after a pop emptied a stack");

endmodule

bind shared_pool_multi_stack smsk_checker u_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for shared_pool_multi_stack: drives push, pop, peek and unused-opcode
// transactions and compares every response against an in-bench model of the shared entry pool.
// Depends on smsk_pkg and the shared_pool_multi_stack RTL.
module testbench;
    import smsk_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [4:0] NULL_LINK  = 5'd16;
    localparam int         POOL_SIZE  = 16;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SETTLE_CYCLES = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic signed [31:0] cfg_data = '0;

    // Model of the pool: data words, links, stack tops and the free-list head.
    logic [31:0] pool_data [POOL_SIZE];
    logic [4:0]  pool_link [POOL_SIZE];
    logic [4:0]  top_of [4];
    logic [4:0]  free_at;
    logic [31:0] empty_word;

    rsp_t expected_rsp [$];
    int   fail_count = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   rcv_stall_pct = 0;

    shared_pool_multi_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic reset_pool_model();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_data[i] = '0;
            pool_link[i] = (i + 1 < POOL_SIZE) ? 5'(i + 1) : NULL_LINK;
        end
        for (int s = 0; s < 4; s++)
            top_of[s] = NULL_LINK;
        free_at = 5'd0;
        empty_word = '0;
    endtask

    // Applies one operation to the model and returns the response it should produce.
    function automatic rsp_t predict_op(input req_t r);
        rsp_t       o;
        logic [4:0] e;
        o = '0;
        case (r.operation)
            OP_PUSH:
                if (!free_at[4])
                begin
                    e = free_at;
                    pool_data[e[3:0]] = r.push_value;
                    free_at = pool_link[e[3:0]];
                    pool_link[e[3:0]] = top_of[r.stack_id];
                    top_of[r.stack_id] = e;
                    o.ok = 1'b1;
                end
            OP_POP:
                if (!top_of[r.stack_id][4])
                begin
                    e = top_of[r.stack_id];
                    top_of[r.stack_id] = pool_link[e[3:0]];
                    pool_link[e[3:0]] = free_at;
                    free_at = e;
                    o.ok = 1'b1;
                end
            OP_PEEK:
                o.ok = !top_of[r.stack_id][4];
            default:
                o.ok = 1'b0;
        endcase
        o.stack_empty = top_of[r.stack_id][4];
        o.top_value = o.stack_empty ? empty_word : pool_data[top_of[r.stack_id][3:0]];
        o.pool_full = free_at[4];
        return o;
    endfunction

    // Called just after a rising edge; leaves the transaction accepted at the latest edge.
    task automatic send_op(input logic [1:0] op, input logic [1:0] sid, input logic [31:0] value);
        req_t item;
        item.operation = op;
        item.stack_id = sid;
        item.push_value = value;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req <= item;
        req_valid <= 1'b1;
        expected_rsp.insert(expected_rsp.size(), predict_op(item));
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_empty_value(input logic [31:0] value);
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        empty_word = value;
    endtask

    task automatic test_empty_stacks();
        for (int s = 0; s < 4; s++)
            send_op(OP_POP, 2'(s), 32'h1234_5678);
        send_op(OP_PEEK, 2'd2, '0);
        send_op(OP_UNUSED, 2'd1, 32'hFFFF_FFFF);
    endtask

    // Fills the whole pool across all stacks, then tries one push too many.
    task automatic test_fill_pool();
        logic [31:0] corner [6];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA};
        for (int i = 0; i < POOL_SIZE; i++)
            send_op(OP_PUSH, 2'(i % 4), (i < 6) ? corner[i] : $urandom);
        send_op(OP_PUSH, 2'd3, 32'hDEAD_BEEF);
        send_op(OP_PEEK, 2'd0, '0);
        send_op(OP_UNUSED, 2'd3, '0);
    endtask

    task automatic test_random_ops(input int count, input int s_pct, input int r_pct);
        logic [1:0]  op;
        logic [31:0] value;
        int          pick;
        bit          push_heavy;
        send_idle_pct = s_pct;
        rcv_stall_pct = r_pct;
        push_heavy = $urandom_range(1);
        for (int n = 0; n < count; n++)
        begin
            // Alternate between filling and draining so both the full pool and
            // empty stacks are visited repeatedly.
            if (n % 32 == 0)
                push_heavy = !push_heavy;
            if (n == count / 2)
                wait_for_responses();
            pick = $urandom_range(99);
            if (pick < 5)
                op = OP_UNUSED;
            else if (pick < 20)
                op = OP_PEEK;
            else if (pick < (push_heavy ? 75 : 35))
                op = OP_PUSH;
            else
                op = OP_POP;
            case ($urandom_range(7))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_op(op, 2'($urandom_range(3)), value);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("ok", 32'(want.ok), 32'(rsp.ok));
                check_field("top_value", want.top_value, rsp.top_value);
                check_field("stack_empty", 32'(want.stack_empty), 32'(rsp.stack_empty));
                check_field("pool_full", 32'(want.pool_full), 32'(rsp.pool_full));
            end
        end
    end

    // Ends the run if no transaction of any kind completes for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        reset_pool_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_empty_value(-32'sd1);
        test_empty_stacks();
        test_fill_pool();
        write_empty_value(32'h8000_0000);
        test_random_ops(460, 12, 77);
        write_empty_value(32'h7FFF_FFFF);
        test_random_ops(460, 77, 12);
        write_empty_value($urandom);
        test_random_ops(460, 0, 0);
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
